// ===== hw/rtl/sflp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_pkg
// Types, codes and constants shared by the slab free list pool modules.
// ----------------------------------------------------------------------------
package sflp_pkg;

   localparam int SLAB_COUNT       = 4;
   localparam int OBJECTS_MAX      = 256;
   localparam int OFFSET_BITS      = 28;

   localparam int SLAB_BITS        = 2;
   localparam int OBJECT_BITS      = 8;
   localparam int SLAB_CNT_BITS    = $clog2(SLAB_COUNT + 1);
   localparam int COUNT_BITS       = $clog2(OBJECTS_MAX + 1);
   localparam int LINK_DEPTH       = SLAB_COUNT * OBJECTS_MAX;

   localparam int OBJECT_SIZE_BITS = 17;
   localparam int COUNT_REG_BITS   = 9;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = 17;
   localparam int STATUS_BITS      = 2;

   // Object size plus header, rounded up to the header alignment.
   localparam int PADDED_BITS      = OBJECT_SIZE_BITS + 1;
   localparam int HEADER_BYTES     = 8;
   localparam int ALIGN_MASK       = 7;

   localparam logic [OBJECT_SIZE_BITS-1:0] OBJECT_SIZE_RESET = 17'd64;
   localparam logic [COUNT_REG_BITS-1:0]   OBJECTS_RESET     = 9'd256;

   localparam logic [CSR_INDEX_BITS-1:0] REG_OBJECT_SIZE      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OBJECTS_PER_SLAB = 1'b1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_GRANTED   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_PUT       = 2'd2;

   typedef struct packed {
      logic                   valid;
      logic [SLAB_BITS-1:0]   slab;
      logic [OBJECT_BITS-1:0] object;
   } link_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   build_start;
      logic                   build_step;
      logic                   get_read;
      logic                   put_apply;
      logic                   load_grant;
      logic                   load_status;
      logic [STATUS_BITS-1:0] status;
   } sflp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_valid;
      logic pool_full;
      logic build_last;
      logic out_free;
      logic restart;
   } sflp_stat_type;

   // Objects per slab as used: zero acts as one, large values clip to the maximum.
   // The largest padded size times the largest count stays below 2^OFFSET_BITS,
   // so the offset range never cuts the count further.
   function automatic logic [COUNT_BITS-1:0] effective_count(
      input logic [COUNT_REG_BITS-1:0] value
   );
      logic [COUNT_BITS-1:0] result;
      if (value == '0) begin
         result = COUNT_BITS'(1);
      end else if (value > COUNT_REG_BITS'(OBJECTS_MAX)) begin
         result = COUNT_BITS'(OBJECTS_MAX);
      end else begin
         result = COUNT_BITS'(value);
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/sflp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sflp_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sflp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_ctrl
// Controller: sequences gets, puts and slab chain builds.
// ----------------------------------------------------------------------------
module sflp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_stall,
   input  sflp_pkg::sflp_stat_type stat,
   output sflp_pkg::sflp_cmd_type  cmd
);
   import sflp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_BUILD_INIT = 7'b0000010,
      ST_BUILD_GET  = 7'b0000100,
      ST_ISSUE      = 7'b0001000,
      ST_LOOKUP     = 7'b0010000,
      ST_PUT_DONE   = 7'b0100000,
      ST_EXHAUSTED  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_PUT) begin
                  cmd.put_apply = 1'b1;
                  state_in      = ST_PUT_DONE;
               end else if (stat.head_valid) begin
                  cmd.get_read = 1'b1;
                  state_in     = ST_LOOKUP;
               end else if (stat.pool_full) begin
                  state_in = ST_EXHAUSTED;
               end else begin
                  cmd.build_start = 1'b1;
                  state_in        = ST_BUILD_GET;
               end
            end
         end
         ST_BUILD_INIT: begin
            cmd.build_step = 1'b1;
            if (stat.build_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_BUILD_GET: begin
            cmd.build_step = 1'b1;
            if (stat.build_last) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.get_read = 1'b1;
            state_in     = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.out_free) begin
               cmd.load_grant = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_PUT_DONE: begin
            if (stat.out_free) begin
               cmd.load_status = 1'b1;
               cmd.status      = STATUS_PUT;
               state_in        = ST_IDLE;
            end
         end
         ST_EXHAUSTED: begin
            if (stat.out_free) begin
               cmd.load_status = 1'b1;
               cmd.status      = STATUS_EXHAUSTED;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A register write restarts the pool with a fresh slab 0 chain.
      if (stat.restart) begin
         cmd      = '0;
         state_in = ST_BUILD_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BUILD_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // The lookup only follows a cycle that issued the link read, or a lookup that waited.
   a_lookup_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |->
         ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_ISSUE ||
          $past(state_ff) == ST_LOOKUP))
      else $error("lookup without a preceding link read");

   // A slab expansion starts only from idle with a free slab left.
   a_expand_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD_GET && $past(state_ff) != ST_BUILD_GET) |->
         ($past(state_ff) == ST_IDLE && !$past(stat.pool_full)))
      else $error("slab expansion started without a free slab");
`endif

endmodule

// ===== hw/rtl/sflp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflp_datapath
// Datapath: registers, list head, link memory, offset math and output word.
// ----------------------------------------------------------------------------
module sflp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [sflp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sflp_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic [sflp_pkg::SLAB_BITS-1:0]        req_put_slab,
   input  logic [sflp_pkg::OBJECT_BITS-1:0]      req_put_object,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [sflp_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [sflp_pkg::SLAB_BITS-1:0]        rsp_slab,
   output logic [sflp_pkg::OBJECT_BITS-1:0]      rsp_object,
   output logic [sflp_pkg::OFFSET_BITS-1:0]      rsp_payload_offset,
   input  sflp_pkg::sflp_cmd_type                cmd,
   output sflp_pkg::sflp_stat_type               stat
);
   import sflp_pkg::*;

   localparam int ADDR_BITS = $clog2(LINK_DEPTH);
   localparam int PROD_BITS = OBJECT_BITS + PADDED_BITS;

   logic [OBJECT_SIZE_BITS-1:0] object_size_ff, object_size_in;
   logic [COUNT_REG_BITS-1:0]   objects_per_slab_ff, objects_per_slab_in;
   link_type                    head_ff, head_in;
   logic [SLAB_CNT_BITS-1:0]    slabs_in_use_ff, slabs_in_use_in;
   logic [OBJECT_BITS-1:0]      build_idx_ff, build_idx_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]      rsp_status_ff, rsp_status_in;
   logic [SLAB_BITS-1:0]        rsp_slab_ff, rsp_slab_in;
   logic [OBJECT_BITS-1:0]      rsp_object_ff, rsp_object_in;
   logic [OFFSET_BITS-1:0]      rsp_offset_ff, rsp_offset_in;

   logic                        restart;
   logic [COUNT_BITS-1:0]       eff_count;
   logic [PADDED_BITS-1:0]      padded_size;
   logic [PROD_BITS-1:0]        product;
   logic                        build_last;
   link_type                    build_entry;
   logic                        put_ok;
   logic                        out_free;

   logic                        ram_wr_en;
   logic [ADDR_BITS-1:0]        ram_wr_addr;
   link_type                    ram_wr_data;
   logic [ADDR_BITS-1:0]        ram_rd_addr;
   link_type                    ram_rd_data;

   // Register writes.
   always_comb begin
      restart             = 1'b0;
      object_size_in      = object_size_ff;
      objects_per_slab_in = objects_per_slab_ff;
      if (csr_write) begin
         case (csr_index)
            REG_OBJECT_SIZE: begin
               object_size_in = csr_data[OBJECT_SIZE_BITS-1:0];
               restart        = 1'b1;
            end
            REG_OBJECTS_PER_SLAB: begin
               objects_per_slab_in = csr_data[COUNT_REG_BITS-1:0];
               restart             = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign eff_count   = effective_count(objects_per_slab_ff);
   assign padded_size = (PADDED_BITS'(object_size_ff) + PADDED_BITS'(HEADER_BYTES + ALIGN_MASK))
                        & ~PADDED_BITS'(ALIGN_MASK);
   assign product     = PROD_BITS'(head_ff.object) * PROD_BITS'(padded_size);

   // The chain being built always belongs to the slab in the head.
   assign build_last         = (COUNT_BITS'(build_idx_ff) + COUNT_BITS'(1)) == eff_count;
   assign build_entry.valid  = !build_last;
   assign build_entry.slab   = head_ff.slab;
   assign build_entry.object = build_last ? '0 : build_idx_ff + OBJECT_BITS'(1);

   assign put_ok = (SLAB_CNT_BITS'(req_put_slab) < slabs_in_use_ff) &&
                   (COUNT_BITS'(req_put_object) < eff_count);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Link memory port control.
   assign ram_wr_en   = cmd.build_step || (cmd.put_apply && put_ok);
   assign ram_wr_addr = cmd.build_step ? {head_ff.slab, build_idx_ff}
                                       : {req_put_slab, req_put_object};
   assign ram_wr_data = cmd.build_step ? build_entry : head_ff;
   assign ram_rd_addr = {head_ff.slab, head_ff.object};

   sflp_ram #(
      .WIDTH ($bits(link_type)),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.get_read),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // List head, slab usage and build counter.
   always_comb begin
      head_in         = head_ff;
      slabs_in_use_in = slabs_in_use_ff;
      build_idx_in    = build_idx_ff;
      if (restart) begin
         head_in         = '{valid: 1'b1, slab: '0, object: '0};
         slabs_in_use_in = SLAB_CNT_BITS'(1);
         build_idx_in    = '0;
      end else if (cmd.build_start) begin
         head_in         = '{valid: 1'b1, slab: slabs_in_use_ff[SLAB_BITS-1:0], object: '0};
         slabs_in_use_in = slabs_in_use_ff + SLAB_CNT_BITS'(1);
         build_idx_in    = '0;
      end else if (cmd.build_step) begin
         build_idx_in = build_idx_ff + OBJECT_BITS'(1);
      end else if (cmd.put_apply && put_ok) begin
         head_in = '{valid: 1'b1, slab: req_put_slab, object: req_put_object};
      end else if (cmd.load_grant) begin
         head_in = ram_rd_data;
      end
   end

   // Output word.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slab_in   = rsp_slab_ff;
      rsp_object_in = rsp_object_ff;
      rsp_offset_in = rsp_offset_ff;
      if (cmd.load_grant) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_GRANTED;
         rsp_slab_in   = head_ff.slab;
         rsp_object_in = head_ff.object;
         rsp_offset_in = OFFSET_BITS'(product) + OFFSET_BITS'(HEADER_BYTES);
      end else if (cmd.load_status) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         rsp_slab_in   = '0;
         rsp_object_in = '0;
         rsp_offset_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff      <= OBJECT_SIZE_RESET;
         objects_per_slab_ff <= OBJECTS_RESET;
         head_ff             <= '{valid: 1'b1, slab: '0, object: '0};
         slabs_in_use_ff     <= SLAB_CNT_BITS'(1);
         build_idx_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         object_size_ff      <= object_size_in;
         objects_per_slab_ff <= objects_per_slab_in;
         head_ff             <= head_in;
         slabs_in_use_ff     <= slabs_in_use_in;
         build_idx_ff        <= build_idx_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slab_ff   <= rsp_slab_in;
      rsp_object_ff <= rsp_object_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign stat.head_valid = head_ff.valid;
   assign stat.pool_full  = slabs_in_use_ff >= SLAB_CNT_BITS'(SLAB_COUNT);
   assign stat.build_last = build_last;
   assign stat.out_free   = out_free;
   assign stat.restart    = restart;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slab           = rsp_slab_ff;
   assign rsp_object         = rsp_object_ff;
   assign rsp_payload_offset = rsp_offset_ff;

`ifndef ASSERT_OFF
   a_slabs_range: assert property (@(posedge clock) disable iff (reset)
      (slabs_in_use_ff != '0) && (slabs_in_use_ff <= SLAB_CNT_BITS'(SLAB_COUNT)))
      else $error("slab usage count out of range");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_grant || cmd.load_status) |-> out_free)
      else $error("output word overwritten before it was taken");

   a_expand_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.build_start |->
         (!head_ff.valid && slabs_in_use_ff < SLAB_CNT_BITS'(SLAB_COUNT)))
      else $error("slab expansion while the list is not empty or pool is full");
`endif

endmodule

// ===== hw/rtl/slab_free_list_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_free_list_pool
// Fixed-size object pool kept as a singly linked free list over slabs.
// ----------------------------------------------------------------------------
// Each request word is a get or a put and yields one response word. A get
// whose list head is valid issues a link memory read and loads the response
// from its registered read data. A get that finds the list empty builds the
// next slab's chain first, one link per cycle, and then reads the link memory;
// a get with no free slab left answers exhausted. After reset and after each
// register write the block builds the slab 0 chain, one link per cycle for the
// effective object count, and holds req_stall high meanwhile. The output
// register lets a request be taken while the previous response still waits on
// rsp_stall.
module slab_free_list_pool (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [sflp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sflp_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [sflp_pkg::SLAB_BITS-1:0]        req_put_slab,
   input  logic [sflp_pkg::OBJECT_BITS-1:0]      req_put_object,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sflp_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [sflp_pkg::SLAB_BITS-1:0]        rsp_slab,
   output logic [sflp_pkg::OBJECT_BITS-1:0]      rsp_object,
   output logic [sflp_pkg::OFFSET_BITS-1:0]      rsp_payload_offset
);
   import sflp_pkg::*;

   sflp_cmd_type  cmd;
   sflp_stat_type stat;

   sflp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   sflp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_put_slab       (req_put_slab),
      .req_put_object     (req_put_object),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_slab           (rsp_slab),
      .rsp_object         (rsp_object),
      .rsp_payload_offset (rsp_payload_offset),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
